>>> sv/bbs_pkg.sv
// Shared types and constants for the bidirectional bias sweep sequencer.
`timescale 1ns / 1ps

package bbs_pkg;

  localparam int WARMUP_READS = 5;
  localparam int MAX_AVERAGE  = 32;

  localparam int CFG_W   = 16;
  localparam int AVGR_W  = 8;
  localparam int CUR_W   = 32;
  localparam int TS_W    = 32;
  localparam int OUTL_W  = 17;
  localparam int LVL_W   = 18;
  localparam int CALC_W  = 19;
  localparam int WARM_W  = 3;
  localparam int AVG_W   = $clog2(MAX_AVERAGE + 1);
  localparam int SUM_W   = CUR_W + $clog2(MAX_AVERAGE);
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int IDX_W   = 2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_START = 2'd0,
    REG_STOP  = 2'd1,
    REG_STEP  = 2'd2,
    REG_AVG   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    LS_START = 2'd0,
    LS_FWD   = 2'd1,
    LS_TURN  = 2'd2,
    LS_REV   = 2'd3
  } lvl_sel_t;

  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_REC = 1'b1;

  typedef struct packed {
    logic     start_sweep;
    logic     warm_inc;
    logic     warm_done;
    logic     accum;
    logic     div_start;
    logic     next_load;
    lvl_sel_t lvl_sel;
    logic     load_rec;
    logic     rec_last;
    logic     load_cmd;
  } ctl_cmd_t;

  typedef struct packed {
    logic fwd_go;
    logic rev_go;
    logic ends_differ;
    logic warm_last;
    logic point_full;
    logic div_busy;
    logic out_free;
  } dp_sts_t;

endpackage

>>> sv/bbs_div.sv
// Restoring divider that produces one quotient bit per cycle for the point mean.
`timescale 1ns / 1ps

module bbs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bbs_pkg::SUM_W-1:0]     dividend_mag,
  input  logic                          negative,
  input  logic [bbs_pkg::AVG_W-1:0]     divisor,
  output logic                          busy,
  output logic signed [bbs_pkg::CUR_W-1:0] quotient
);

  logic                          busy_r;
  logic [bbs_pkg::DCNT_W-1:0]    cnt_r;
  logic [bbs_pkg::SUM_W-1:0]     quo_r;
  logic [bbs_pkg::AVG_W-1:0]     rem_r;
  logic [bbs_pkg::AVG_W-1:0]     div_r;
  logic                          neg_r;
  logic [bbs_pkg::AVG_W:0]       rem_sh;
  logic                          ge;
  logic [bbs_pkg::AVG_W:0]       rem_sub;
  logic [bbs_pkg::SUM_W-1:0]     quo_signed;

  assign rem_sh  = {rem_r, quo_r[bbs_pkg::SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= bbs_pkg::DCNT_W'(bbs_pkg::SUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == bbs_pkg::DCNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend_mag;
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= negative;
    end else if (busy_r) begin
      quo_r <= {quo_r[bbs_pkg::SUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[bbs_pkg::AVG_W-1:0] : rem_sh[bbs_pkg::AVG_W-1:0];
    end
  end

  // Truncation toward zero falls out of dividing the magnitude and restoring the sign.
  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient   = quo_signed[bbs_pkg::CUR_W-1:0];
  assign busy       = busy_r;

endmodule

>>> sv/bbs_datapath.sv
// Datapath: settings, level stepping, point accumulation, divider and output register.
`timescale 1ns / 1ps

module bbs_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bbs_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bbs_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic signed [bbs_pkg::CUR_W-1:0]  in_current_na,
  input  logic [bbs_pkg::TS_W-1:0]          in_timestamp_ms,
  input  bbs_pkg::ctl_cmd_t                 cmd,
  output bbs_pkg::dp_sts_t                  sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic signed [bbs_pkg::OUTL_W-1:0] out_level_mv,
  output logic signed [bbs_pkg::CUR_W-1:0]  out_mean_current_na,
  output logic [bbs_pkg::TS_W-1:0]          out_elapsed_ms,
  output logic                              out_last
);

  logic signed [bbs_pkg::CFG_W-1:0]  start_cfg_r;
  logic signed [bbs_pkg::CFG_W-1:0]  stop_cfg_r;
  logic signed [bbs_pkg::CFG_W-1:0]  step_cfg_r;
  logic [bbs_pkg::AVGR_W-1:0]        avg_cfg_r;

  logic signed [bbs_pkg::CFG_W-1:0]  from_r;
  logic signed [bbs_pkg::CFG_W-1:0]  to_r;
  logic [bbs_pkg::CFG_W-1:0]         step_r;
  logic [bbs_pkg::AVG_W-1:0]         avg_r;
  logic signed [bbs_pkg::LVL_W-1:0]  present_r;
  logic signed [bbs_pkg::LVL_W-1:0]  next_r;
  logic signed [bbs_pkg::SUM_W-1:0]  sum_r;
  logic [bbs_pkg::AVG_W-1:0]         cnt_r;
  logic [bbs_pkg::WARM_W-1:0]        warm_r;
  logic [bbs_pkg::TS_W-1:0]          t0_r;
  logic [bbs_pkg::TS_W-1:0]          elapsed_r;

  logic                              out_valid_r;
  logic                              out_kind_r;
  logic signed [bbs_pkg::OUTL_W-1:0] out_level_r;
  logic signed [bbs_pkg::CUR_W-1:0]  out_mean_r;
  logic [bbs_pkg::TS_W-1:0]          out_elapsed_r;
  logic                              out_last_r;

  logic [bbs_pkg::CFG_W-1:0]         step_clean;
  logic [bbs_pkg::AVG_W-1:0]         avg_clean;
  logic signed [bbs_pkg::CALC_W-1:0] p_ext, s_ext, f_ext, t_ext;
  logic signed [bbs_pkg::CALC_W-1:0] fwd_next, turn_lvl, rev_next, sel_lvl;
  logic                              fwd_up, rev_up;
  logic [bbs_pkg::SUM_W-1:0]         sum_mag;
  logic signed [bbs_pkg::CUR_W-1:0]  div_quo;
  logic                              div_busy;

  // Settings cleanup at start: zero step becomes one, sign dropped; average clamped.
  always_comb begin
    if (step_cfg_r == '0) begin
      step_clean = bbs_pkg::CFG_W'(1);
    end else if (step_cfg_r[bbs_pkg::CFG_W-1]) begin
      step_clean = ~step_cfg_r + 1'b1;
    end else begin
      step_clean = step_cfg_r;
    end
    if (avg_cfg_r == '0) begin
      avg_clean = bbs_pkg::AVG_W'(1);
    end else if (avg_cfg_r > bbs_pkg::AVGR_W'(bbs_pkg::MAX_AVERAGE)) begin
      avg_clean = bbs_pkg::AVG_W'(bbs_pkg::MAX_AVERAGE);
    end else begin
      avg_clean = avg_cfg_r[bbs_pkg::AVG_W-1:0];
    end
  end

  assign p_ext = bbs_pkg::CALC_W'(present_r);
  assign s_ext = signed'({{(bbs_pkg::CALC_W-bbs_pkg::CFG_W){1'b0}}, step_r});
  assign f_ext = bbs_pkg::CALC_W'(from_r);
  assign t_ext = bbs_pkg::CALC_W'(to_r);

  assign fwd_up   = to_r >= from_r;
  assign fwd_next = fwd_up ? (p_ext + s_ext) : (p_ext - s_ext);
  assign turn_lvl = (from_r < to_r) ? (t_ext - s_ext) : (t_ext + s_ext);
  assign rev_up   = f_ext >= p_ext;
  assign rev_next = rev_up ? (p_ext + s_ext) : (p_ext - s_ext);

  always_comb begin
    case (cmd.lvl_sel)
      bbs_pkg::LS_FWD:  sel_lvl = fwd_next;
      bbs_pkg::LS_TURN: sel_lvl = turn_lvl;
      bbs_pkg::LS_REV:  sel_lvl = rev_next;
      default:          sel_lvl = f_ext;
    endcase
  end

  assign sum_mag = sum_r[bbs_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  bbs_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (cmd.div_start),
    .dividend_mag (sum_mag),
    .negative     (sum_r[bbs_pkg::SUM_W-1]),
    .divisor      (avg_r),
    .busy         (div_busy),
    .quotient     (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_cfg_r <= '0;
      stop_cfg_r  <= '0;
      step_cfg_r  <= bbs_pkg::CFG_W'(1);
      avg_cfg_r   <= bbs_pkg::AVGR_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bbs_pkg::REG_START: start_cfg_r <= cfg_wdata;
        bbs_pkg::REG_STOP:  stop_cfg_r  <= cfg_wdata;
        bbs_pkg::REG_STEP:  step_cfg_r  <= cfg_wdata;
        bbs_pkg::REG_AVG:   avg_cfg_r   <= cfg_wdata[bbs_pkg::AVGR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_r    <= '0;
      to_r      <= '0;
      step_r    <= bbs_pkg::CFG_W'(1);
      avg_r     <= bbs_pkg::AVG_W'(1);
      present_r <= '0;
      next_r    <= '0;
      sum_r     <= '0;
      cnt_r     <= '0;
      warm_r    <= '0;
      t0_r      <= '0;
      elapsed_r <= '0;
    end else begin
      if (cmd.start_sweep) begin
        from_r    <= start_cfg_r;
        to_r      <= stop_cfg_r;
        step_r    <= step_clean;
        avg_r     <= avg_clean;
        present_r <= bbs_pkg::LVL_W'(start_cfg_r);
        next_r    <= bbs_pkg::LVL_W'(start_cfg_r);
        warm_r    <= '0;
        if (bbs_pkg::WARMUP_READS == 0) begin
          t0_r <= in_timestamp_ms;
        end
      end
      if (cmd.warm_inc) begin
        warm_r <= warm_r + 1'b1;
      end
      if (cmd.warm_done) begin
        t0_r <= in_timestamp_ms;
      end
      if (cmd.start_sweep || cmd.warm_done || cmd.div_start) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (cmd.accum) begin
        sum_r     <= sum_r + bbs_pkg::SUM_W'(in_current_na);
        cnt_r     <= cnt_r + 1'b1;
        elapsed_r <= in_timestamp_ms - t0_r;
      end
      if (cmd.next_load) begin
        next_r <= sel_lvl[bbs_pkg::LVL_W-1:0];
      end
      if (cmd.load_cmd) begin
        present_r <= next_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_rec || cmd.load_cmd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rec) begin
      out_kind_r    <= bbs_pkg::KIND_REC;
      out_level_r   <= present_r[bbs_pkg::OUTL_W-1:0];
      out_mean_r    <= div_quo;
      out_elapsed_r <= elapsed_r;
      out_last_r    <= cmd.rec_last;
    end else if (cmd.load_cmd) begin
      out_kind_r    <= bbs_pkg::KIND_CMD;
      out_level_r   <= next_r[bbs_pkg::OUTL_W-1:0];
      out_mean_r    <= '0;
      out_elapsed_r <= '0;
      out_last_r    <= 1'b1;
    end
  end

  assign sts.fwd_go      = fwd_up ? (fwd_next <= t_ext) : (fwd_next >= t_ext);
  assign sts.rev_go      = rev_up ? (rev_next <= f_ext) : (rev_next >= f_ext);
  assign sts.ends_differ = to_r != from_r;
  assign sts.warm_last   = ({1'b0, warm_r} + 1'b1) >= (bbs_pkg::WARM_W + 1)'(bbs_pkg::WARMUP_READS);
  assign sts.point_full  = ({1'b0, cnt_r} + 1'b1) >= {1'b0, avg_r};
  assign sts.div_busy    = div_busy;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_level_mv        = out_level_r;
  assign out_mean_current_na = out_mean_r;
  assign out_elapsed_ms      = out_elapsed_r;
  assign out_last            = out_last_r;

endmodule

>>> sv/bbs_ctrl.sv
// Controller: sweep phase and the sequencing of one input transfer through the datapath.
`timescale 1ns / 1ps

module bbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_operation,
  output logic                in_ready,
  input  bbs_pkg::dp_sts_t    sts,
  output bbs_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [4:0] {
    CS_READY = 5'b00001,
    CS_DLOAD = 5'b00010,
    CS_DIV   = 5'b00100,
    CS_REC   = 5'b01000,
    CS_CMD   = 5'b10000
  } ctl_state_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_WARMUP  = 4'b0010,
    PH_FORWARD = 4'b0100,
    PH_REVERSE = 4'b1000
  } phase_t;

  ctl_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       end_r, end_nxt;
  logic       accept;

  assign in_ready = state_r == CS_READY;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    end_nxt   = end_r;
    cmd       = '0;
    case (state_r)
      CS_READY: begin
        if (accept) begin
          case (in_operation)
            bbs_pkg::OP_START: begin
              cmd.start_sweep = 1'b1;
              phase_nxt = (bbs_pkg::WARMUP_READS == 0) ? PH_FORWARD : PH_WARMUP;
              state_nxt = CS_CMD;
            end
            bbs_pkg::OP_STOP: begin
              phase_nxt = PH_IDLE;
            end
            bbs_pkg::OP_READ: begin
              case (phase_r)
                PH_WARMUP: begin
                  cmd.warm_inc = 1'b1;
                  if (sts.warm_last) begin
                    cmd.warm_done = 1'b1;
                    phase_nxt = PH_FORWARD;
                  end
                end
                PH_FORWARD, PH_REVERSE: begin
                  cmd.accum = 1'b1;
                  if (sts.point_full) begin
                    state_nxt = CS_DLOAD;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      CS_DLOAD: begin
        // The divider takes the finished sum here while the next level is chosen.
        cmd.div_start = 1'b1;
        cmd.next_load = 1'b1;
        end_nxt = 1'b0;
        if (phase_r == PH_FORWARD) begin
          if (sts.fwd_go) begin
            cmd.lvl_sel = bbs_pkg::LS_FWD;
          end else if (sts.ends_differ) begin
            cmd.lvl_sel = bbs_pkg::LS_TURN;
            phase_nxt = PH_REVERSE;
          end else begin
            end_nxt = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end else begin
          cmd.lvl_sel = bbs_pkg::LS_REV;
          if (!sts.rev_go) begin
            end_nxt = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        state_nxt = CS_DIV;
      end
      CS_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = CS_REC;
        end
      end
      CS_REC: begin
        if (sts.out_free) begin
          cmd.load_rec = 1'b1;
          cmd.rec_last = end_r;
          state_nxt = end_r ? CS_READY : CS_CMD;
        end
      end
      CS_CMD: begin
        if (sts.out_free) begin
          cmd.load_cmd = 1'b1;
          state_nxt = CS_READY;
        end
      end
      default: state_nxt = CS_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_READY;
      phase_r <= PH_IDLE;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      end_r   <= end_nxt;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_rec || cmd.load_cmd) |-> sts.out_free)
    else $error("output register loaded while holding an untaken transfer");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CS_DLOAD |=> sts.div_busy)
    else $error("divider not running after launch");

  a_rec_then_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_rec && !cmd.rec_last) |=> state_r == CS_CMD)
    else $error("record without final flag not followed by a bias command");

endmodule

>>> sv/bidirectional_bias_sweep_sequencer.sv
// Top level of the bidirectional staircase bias sweep sequencer.
// A start transfer goes to the command state, which loads its bias command into
// the output register once it is free. Stop transfers, warm-up readings and
// readings inside a point finish in the ready state. A point's last reading has
// its record loaded after the launch state, the divider (one quotient bit of the
// mean per cycle over SUM_W = 37 bits), a state to see the divider finish and a
// load state that waits for a free output register. Unless the record is the
// last, the next bias command is loaded as the record is taken. The output
// register holds each result until taken; input is accepted meanwhile, but not
// after a non-last record. Configuration writes take effect at the next start.
`timescale 1ns / 1ps

module bidirectional_bias_sweep_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bbs_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bbs_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_operation,
  input  logic signed [bbs_pkg::CUR_W-1:0]  in_current_na,
  input  logic [bbs_pkg::TS_W-1:0]          in_timestamp_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic signed [bbs_pkg::OUTL_W-1:0] out_level_mv,
  output logic signed [bbs_pkg::CUR_W-1:0]  out_mean_current_na,
  output logic [bbs_pkg::TS_W-1:0]          out_elapsed_ms,
  output logic                              out_last
);

  bbs_pkg::ctl_cmd_t cmd;
  bbs_pkg::dp_sts_t  sts;

  bbs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  bbs_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_current_na       (in_current_na),
    .in_timestamp_ms     (in_timestamp_ms),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_level_mv        (out_level_mv),
    .out_mean_current_na (out_mean_current_na),
    .out_elapsed_ms      (out_elapsed_ms),
    .out_last            (out_last)
  );

endmodule
